// ===== hdl/icvs_pkg.sv =====
// Shared types, constants and codes for the ionic cell voltage step block.
package icvs_pkg;

	localparam int NUM_CELLS_DEF = 256;
	localparam int SUBSTEPS_DEF  = 10;
	localparam int CELL_SPAN     = 256;

	localparam logic signed [23:0] V_RESET   = -24'sd5570560;
	localparam logic signed [25:0] V_BIAS    = 26'sd8847360;
	localparam logic signed [18:0] VN_BIAS   = 19'sd32768;
	localparam logic [16:0]        ONE_Q16   = 17'd65536;
	localparam logic signed [26:0] RECIP_100 = 27'sd42949673;
	localparam logic signed [26:0] K_NA      = 27'sd14321678;
	localparam logic signed [26:0] K_IK      = 27'sd67983;
	localparam logic signed [27:0] IK_HIGH   = 28'sd18204;
	localparam logic signed [28:0] V_MAX     = 29'sd8388607;
	localparam logic signed [28:0] V_MIN     = -29'sd8388608;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_VN   = 4'd1;
	localparam logic [3:0] OP_T1   = 4'd2;
	localparam logic [3:0] OP_T2   = 4'd3;
	localparam logic [3:0] OP_NA   = 4'd4;
	localparam logic [3:0] OP_IK   = 4'd5;
	localparam logic [3:0] OP_G    = 4'd6;
	localparam logic [3:0] OP_DV   = 4'd7;
	localparam logic [3:0] OP_DS   = 4'd8;

	localparam logic [2:0] REG_TIME_STEP   = 3'd0;
	localparam logic [2:0] REG_THRESHOLD   = 3'd1;
	localparam logic [2:0] REG_MAX_DV      = 3'd2;
	localparam logic [2:0] REG_OPEN_FULL   = 3'd3;
	localparam logic [2:0] REG_CLOSED_FULL = 3'd4;
	localparam logic [2:0] REG_OPEN_SUB    = 3'd5;
	localparam logic [2:0] REG_CLOSED_SUB  = 3'd6;

	typedef struct packed {
		logic [7:0]         cell_index;
		logic signed [23:0] stimulus_current;
		logic signed [23:0] diffusion_current;
	} req_t;

	typedef struct packed {
		logic [7:0]         cell_out;
		logic signed [23:0] voltage_out;
		logic [16:0]        gate_out;
		logic               substepped;
	} res_t;

	typedef struct packed {
		logic [15:0] time_step;
		logic [16:0] threshold_vc;
		logic [22:0] max_voltage_change;
		logic [16:0] decay_open_full;
		logic [16:0] decay_closed_full;
		logic [16:0] decay_open_sub;
		logic [16:0] decay_closed_sub;
	} cfg_t;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic [3:0] op;
		logic       commit;
		logic       set_sub;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic above;
		logic reject;
		logic sub;
	} sts_t;

endpackage

// ===== hdl/icvs_ram.sv =====
// Generic single-write, registered-read RAM.
module icvs_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/icvs_regs.sv =====
// Configuration register file behind the APB-style port.
module icvs_regs import icvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step          <= 16'd655;
			cfg_q.threshold_vc       <= 17'd8520;
			cfg_q.max_voltage_change <= 23'd6554;
			cfg_q.decay_open_full    <= 17'd65419;
			cfg_q.decay_closed_full  <= 17'd65528;
			cfg_q.decay_open_sub     <= 17'd65524;
			cfg_q.decay_closed_sub   <= 17'd65535;
		end else if (wr) begin
			case (idx)
				REG_TIME_STEP:   cfg_q.time_step          <= pwdata[15:0];
				REG_THRESHOLD:   cfg_q.threshold_vc       <= pwdata[16:0];
				REG_MAX_DV:      cfg_q.max_voltage_change <= pwdata[22:0];
				REG_OPEN_FULL:   cfg_q.decay_open_full    <= pwdata[16:0];
				REG_CLOSED_FULL: cfg_q.decay_closed_full  <= pwdata[16:0];
				REG_OPEN_SUB:    cfg_q.decay_open_sub     <= pwdata[16:0];
				REG_CLOSED_SUB:  cfg_q.decay_closed_sub   <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TIME_STEP:   prdata = {16'd0, cfg_q.time_step};
			REG_THRESHOLD:   prdata = {15'd0, cfg_q.threshold_vc};
			REG_MAX_DV:      prdata = {9'd0, cfg_q.max_voltage_change};
			REG_OPEN_FULL:   prdata = {15'd0, cfg_q.decay_open_full};
			REG_CLOSED_FULL: prdata = {15'd0, cfg_q.decay_closed_full};
			REG_OPEN_SUB:    prdata = {15'd0, cfg_q.decay_open_sub};
			REG_CLOSED_SUB:  prdata = {15'd0, cfg_q.decay_closed_sub};
			default:         prdata = 32'd0;
		endcase
	end
endmodule

// ===== hdl/icvs_dp.sv =====
// Datapath: cell state memory, shared multiplier and iteration registers.
module icvs_dp import icvs_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF,
	parameter int SUBSTEPS  = SUBSTEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t result,
	output logic done
);
	localparam int DEPTH  = NUM_CELLS > CELL_SPAN ? CELL_SPAN : NUM_CELLS;
	localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int SUB_L  = $clog2(SUBSTEPS);
	localparam int SUB_SH = 16 + SUB_L;
	localparam logic signed [26:0] RECIP_SUB =
		27'(((64'd1 << SUB_SH) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));

	logic [7:0]         cell_q;
	logic signed [23:0] st_q, diff_q, v_q;
	logic [16:0]        h_q, hn_q;
	logic signed [18:0] vn_q;
	logic               above_q, sub_q;
	logic signed [27:0] sum_q, dv_q;
	logic [15:0]        dsub_q;
	logic [DEPTH-1:0]   valid_q;
	logic signed [56:0] prod_s1;
	logic [3:0]         op_s1;
	res_t               res_q;
	logic               done_q;

	logic [40:0]        rdata;
	logic signed [29:0] a_op;
	logic signed [26:0] b_op;
	logic signed [56:0] prod;
	logic signed [40:0] prod_sh;
	logic signed [25:0] vbias;
	logic signed [19:0] vn_ext, vc_ext;
	logic signed [17:0] hinv;
	logic [16:0]        fsel;
	logic [15:0]        dt;
	logic signed [18:0] vn_nx, hc;
	logic [16:0]        hn_nx;
	logic signed [27:0] term;
	logic signed [28:0] dv29, mvc29, vsum;
	logic signed [23:0] vnew;

	icvs_ram #(.WIDTH(41), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (cell_q[AW-1:0]),
		.wdata ({vnew, hn_q}),
		.re    (cmd.accept),
		.raddr (req.cell_index[AW-1:0]),
		.rdata (rdata)
	);

	assign vbias   = 26'(v_q) + V_BIAS;
	assign vn_ext  = 20'(vn_q);
	assign vc_ext  = signed'({3'b000, cfg.threshold_vc});
	assign hinv    = 18'sd65536 - signed'({1'b0, h_q});
	assign dt      = sub_q ? dsub_q : cfg.time_step;
	assign fsel    = sub_q ? (above_q ? cfg.decay_open_sub : cfg.decay_closed_sub)
	                       : (above_q ? cfg.decay_open_full : cfg.decay_closed_full);
	assign prod_sh = prod_s1[56:16];

	always_comb begin
		case (cmd.op)
			OP_VN: begin
				a_op = 30'(vbias);
				b_op = RECIP_100;
			end
			OP_T1: begin
				a_op = 30'(signed'({1'b0, h_q}));
				b_op = 27'(vn_ext - vc_ext);
			end
			OP_T2: begin
				a_op = 30'(prod_sh);
				b_op = 27'(20'sd65536 - vn_ext);
			end
			OP_NA: begin
				a_op = 30'(prod_sh);
				b_op = K_NA;
			end
			OP_IK: begin
				a_op = 30'(vn_q);
				b_op = K_IK;
			end
			OP_G: begin
				a_op = above_q ? 30'(signed'({1'b0, h_q})) : 30'(hinv);
				b_op = 27'(signed'({1'b0, fsel}));
			end
			OP_DV: begin
				a_op = 30'(sum_q);
				b_op = 27'(signed'({1'b0, dt}));
			end
			OP_DS: begin
				a_op = 30'(signed'({1'b0, cfg.time_step}));
				b_op = RECIP_SUB;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
		prod = 57'(a_op) * 57'(b_op);
	end

	// Results taken out of the product register in the cycle after each multiply.
	always_comb begin
		vn_nx = 19'(signed'({1'b0, prod_s1[49:32]})) - VN_BIAS;
		hc    = 19'sd65536 - 19'(prod_sh);
		if (above_q) begin
			hn_nx = (prod_sh > 41'sd65536) ? ONE_Q16 : prod_sh[16:0];
		end else begin
			hn_nx = (hc < 19'sd0) ? 17'd0 : hc[16:0];
		end
		term = (op_s1 == OP_NA) ? (IK_HIGH - 28'(prod_sh)) : 28'(prod_sh);
	end

	assign dv29  = 29'(dv_q);
	assign mvc29 = signed'({6'd0, cfg.max_voltage_change});
	assign vsum  = 29'(v_q) + dv29;
	assign vnew  = (vsum > V_MAX) ? V_MAX[23:0] : ((vsum < V_MIN) ? V_MIN[23:0] : vsum[23:0]);

	assign sts.in_range = {9'd0, cell_q} < 17'(NUM_CELLS);
	assign sts.above    = 20'(vn_nx) >= vc_ext;
	assign sts.reject   = !sub_q && (cfg.max_voltage_change != 23'd0) &&
	                      ((dv29 > mvc29) || (dv29 < -mvc29));
	assign sts.sub      = sub_q;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (cmd.accept) begin
			cell_q <= req.cell_index;
			st_q   <= req.stimulus_current;
			diff_q <= req.diffusion_current;
		end
		if (cmd.load) begin
			v_q <= valid_q[cell_q[AW-1:0]] ? signed'(rdata[40:17]) : V_RESET;
			h_q <= valid_q[cell_q[AW-1:0]] ? rdata[16:0] : ONE_Q16;
		end else if (cmd.commit) begin
			v_q <= vnew;
			h_q <= hn_q;
		end
		case (op_s1)
			OP_VN: begin
				vn_q    <= vn_nx;
				above_q <= sts.above;
			end
			OP_NA, OP_IK: sum_q <= 28'(diff_q) - 28'(st_q) - term;
			OP_G:  hn_q   <= hn_nx;
			OP_DV: dv_q   <= 28'(prod_sh);
			OP_DS: dsub_q <= prod_s1[SUB_SH+15:SUB_SH];
			default: ;
		endcase
		if (cmd.finish) begin
			res_q.cell_out    <= cell_q;
			res_q.voltage_out <= sts.in_range ? v_q : 24'sd0;
			res_q.gate_out    <= sts.in_range ? h_q : 17'd0;
			res_q.substepped  <= sts.in_range & sub_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= OP_NONE;
			sub_q   <= 1'b0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			op_s1  <= cmd.op;
			done_q <= cmd.finish;
			if (cmd.accept) begin
				sub_q <= 1'b0;
			end else if (cmd.set_sub) begin
				sub_q <= 1'b1;
			end
			if (cmd.commit) begin
				valid_q[cell_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;
endmodule

// ===== hdl/icvs_ctrl.sv =====
// Controller: sequences the multiplier operations of each Euler iteration.
module icvs_ctrl import icvs_pkg::*; #(
	parameter int SUBSTEPS = SUBSTEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	localparam int IW = SUBSTEPS > 1 ? $clog2(SUBSTEPS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SUBSTEPS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_VN   = 4'd2;
	localparam logic [3:0] S_VNW  = 4'd3;
	localparam logic [3:0] S_T1   = 4'd4;
	localparam logic [3:0] S_T2   = 4'd5;
	localparam logic [3:0] S_NA   = 4'd6;
	localparam logic [3:0] S_IK   = 4'd7;
	localparam logic [3:0] S_G    = 4'd8;
	localparam logic [3:0] S_DV   = 4'd9;
	localparam logic [3:0] S_DVW  = 4'd10;
	localparam logic [3:0] S_CHK  = 4'd11;
	localparam logic [3:0] S_DS   = 4'd12;
	localparam logic [3:0] S_DSW  = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0]    state_q, state_nx;
	logic [IW-1:0] iter_q, iter_nx;

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_NONE;
		state_nx = state_q;
		iter_nx  = iter_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_nx   = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.in_range) begin
					cmd.load = 1'b1;
					state_nx = S_VN;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_VN: begin
				cmd.op   = OP_VN;
				state_nx = S_VNW;
			end
			S_VNW: state_nx = sts.above ? S_T1 : S_IK;
			S_T1: begin
				cmd.op   = OP_T1;
				state_nx = S_T2;
			end
			S_T2: begin
				cmd.op   = OP_T2;
				state_nx = S_NA;
			end
			S_NA: begin
				cmd.op   = OP_NA;
				state_nx = S_G;
			end
			S_IK: begin
				cmd.op   = OP_IK;
				state_nx = S_G;
			end
			S_G: begin
				cmd.op   = OP_G;
				state_nx = S_DV;
			end
			S_DV: begin
				cmd.op   = OP_DV;
				state_nx = S_DVW;
			end
			S_DVW: state_nx = S_CHK;
			S_CHK: begin
				if (sts.reject) begin
					cmd.set_sub = 1'b1;
					state_nx    = S_DS;
				end else begin
					cmd.commit = 1'b1;
					if (sts.sub && (iter_q != LAST)) begin
						iter_nx  = iter_q + IW'(1);
						state_nx = S_VN;
					end else begin
						state_nx = S_DONE;
					end
				end
			end
			S_DS: begin
				cmd.op   = OP_DS;
				iter_nx  = '0;
				state_nx = S_DSW;
			end
			S_DSW: state_nx = S_VN;
			S_DONE: begin
				cmd.finish = 1'b1;
				state_nx   = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_nx;
			iter_q  <= iter_nx;
		end
	end

	assign busy = state_q != S_IDLE;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> state_q == S_IDLE)
		else $error("finish not followed by idle");
	a_no_commit_reject: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.reject)
		else $error("rejected step committed");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= LAST)
		else $error("substep counter out of range");
	a_reject_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && sts.reject) |=> sts.sub)
		else $error("rejection did not switch to substeps");
endmodule

// ===== hdl/ionic_cell_voltage_step.sv =====
// Top level of the per-cell ionic voltage step engine.
// Advances one cell of a three-current ionic membrane model by one forward
// Euler step per request. A request is taken when start is high and busy is
// low; the result follows on result with done high for exactly one cycle,
// and the receiver cannot stall it. Every iteration runs on one shared
// 30x27 multiplier, so a step takes longer when the cell is above the sodium
// threshold than when below. If the full step's voltage change exceeds a
// nonzero max_voltage_change, it is dropped and SUBSTEPS substeps follow. A
// request for a cell index of NUM_CELLS or more returns zero voltage and
// gate. No clearing pass is needed after reset: each cell reads as -85 mV
// and gate 1.0 until first written. Write configuration only while busy is
// low and no result is pending.
module ionic_cell_voltage_step import icvs_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF,
	parameter int SUBSTEPS  = SUBSTEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Hold the register file; writes land at once.
	icvs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Run the sequencer; it takes no new request until it is idle again.
	icvs_ctrl #(.SUBSTEPS(SUBSTEPS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold cell state and do the arithmetic.
	icvs_dp #(.NUM_CELLS(NUM_CELLS), .SUBSTEPS(SUBSTEPS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");
endmodule
